[design/bvie_pkg.sv]
// ---------------------------------------------------------------------------
// bvie_pkg: shared types and constants for the bounded vector core
// Capacity, field widths, operation and error codes, and the control bundle
// broadcast from the top level to every storage cell.
// ---------------------------------------------------------------------------
package bvie_pkg;

	localparam int DEPTH    = 16;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int INDEX_W  = 4;
	localparam int COUNT_W  = 5;
	localparam int LENGTH_W = 5;
	localparam int ERR_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_PUSH   = 3'd4,
		OP_POP    = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_ASSIGN = 3'd7
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_FULL  = 2'd2,
		ERR_EMPTY = 2'd3
	} err_t;

	typedef struct packed {
		logic                     commit;
		op_t                      op;
		logic [CNT_W-1:0]         idx;
		logic [CNT_W-1:0]         len;
		logic [CNT_W-1:0]         cnt;
		logic                     keep;
		logic signed [DATA_W-1:0] val;
	} cell_ctrl_t;

endpackage

[design/bvie_cell.sv]
// ---------------------------------------------------------------------------
// bvie_cell: one storage slot of the list
// Holds one word and picks its next value from the broadcast request, its
// lower neighbor (insert) or its upper neighbor (erase).
// ---------------------------------------------------------------------------
module bvie_cell (
	input  logic                                clk,
	input  bvie_pkg::cell_ctrl_t                ctrl,
	input  logic [bvie_pkg::CNT_W-1:0]          pos,
	input  logic signed [bvie_pkg::DATA_W-1:0]  lower,
	input  logic signed [bvie_pkg::DATA_W-1:0]  upper,
	output logic signed [bvie_pkg::DATA_W-1:0]  q,
	output logic signed [bvie_pkg::DATA_W-1:0]  d
);

	logic signed [bvie_pkg::DATA_W-1:0] word_q;
	logic [bvie_pkg::CNT_W-1:0]         pos_inc;

	assign pos_inc = pos + bvie_pkg::CNT_W'(1);

	always_comb begin
		d = word_q;
		if (ctrl.commit) begin
			unique case (ctrl.op)
				bvie_pkg::OP_WRITE: begin
					if (pos == ctrl.idx) d = ctrl.val;
				end
				bvie_pkg::OP_INSERT: begin
					// open a gap at idx, entries above move up one slot
					if (pos == ctrl.idx) d = ctrl.val;
					else if (pos > ctrl.idx && pos <= ctrl.len) d = lower;
				end
				bvie_pkg::OP_ERASE: begin
					if (pos >= ctrl.idx && pos_inc < ctrl.len) d = upper;
				end
				bvie_pkg::OP_PUSH: begin
					if (pos == ctrl.len) d = ctrl.val;
				end
				bvie_pkg::OP_ASSIGN: begin
					if (ctrl.keep) begin
						if (pos >= ctrl.len && pos < ctrl.cnt) d = ctrl.val;
					end else if (pos < ctrl.cnt) begin
						d = ctrl.val;
					end
				end
				bvie_pkg::OP_READ,
				bvie_pkg::OP_POP,
				bvie_pkg::OP_CLEAR: begin
					d = word_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		word_q <= d;
	end

	assign q = word_q;

endmodule

[design/bounded_vector_insert_erase_core.sv]
// ---------------------------------------------------------------------------
// bounded_vector_insert_erase_core: fixed-capacity ordered list of words
// Read, write, insert, erase, push, pop, clear and assign/resize on a row of
// cells that all shift together; one result per request.
// ---------------------------------------------------------------------------
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, operation, index, value,   | request
//          | count, keep_existing                           |
//  out     | out_valid, out_ready, read_value, length,      | result
//          | front_value, back_value, error                 |
//
//  One request per cycle while in_ready is high; its result appears in the
//  output register the cycle after it is accepted. Every cell updates in
//  that same cycle, so insert and erase shift the whole row at once.
//  Reset clears the length and output valid; cell contents stay undefined.
//  in_ready drops only while a result waits and out_ready is low.
// ---------------------------------------------------------------------------
module bounded_vector_insert_erase_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [bvie_pkg::OP_W-1:0]              operation,
	input  logic [bvie_pkg::INDEX_W-1:0]           index,
	input  logic signed [bvie_pkg::DATA_W-1:0]     value,
	input  logic [bvie_pkg::COUNT_W-1:0]           count,
	input  logic                                   keep_existing,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [bvie_pkg::DATA_W-1:0]     read_value,
	output logic [bvie_pkg::LENGTH_W-1:0]          length,
	output logic signed [bvie_pkg::DATA_W-1:0]     front_value,
	output logic signed [bvie_pkg::DATA_W-1:0]     back_value,
	output logic [bvie_pkg::ERR_W-1:0]             error
);

	localparam int CW = bvie_pkg::CNT_W;
	localparam int DW = bvie_pkg::DATA_W;
	localparam int N  = bvie_pkg::DEPTH;

	logic [CW-1:0]        len_q;
	logic [CW-1:0]        len_d;
	logic                 out_valid_q;
	logic signed [DW-1:0] read_q;
	logic signed [DW-1:0] front_q;
	logic signed [DW-1:0] back_q;
	bvie_pkg::err_t       err_q;

	logic                 accept;
	bvie_pkg::op_t        op;
	bvie_pkg::err_t       err_d;
	logic                 idx_bad;
	logic                 is_full;
	logic                 cnt_bad;
	logic [CW-1:0]        back_pos;
	logic signed [DW-1:0] rd_d;
	logic signed [DW-1:0] front_d;
	logic signed [DW-1:0] back_d;
	bvie_pkg::cell_ctrl_t ctrl;

	logic signed [DW-1:0] cell_q [N];
	logic signed [DW-1:0] cell_d [N];

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign op       = bvie_pkg::op_t'(operation);

	assign idx_bad = 32'(index) >= 32'(len_q);
	assign is_full = 32'(len_q) >= 32'(N);
	assign cnt_bad = 32'(count) > 32'(N);

	always_comb begin
		err_d = bvie_pkg::ERR_OK;
		len_d = len_q;
		unique case (op)
			bvie_pkg::OP_READ,
			bvie_pkg::OP_WRITE: begin
				if (idx_bad) err_d = bvie_pkg::ERR_RANGE;
			end
			bvie_pkg::OP_INSERT: begin
				if (idx_bad) err_d = bvie_pkg::ERR_RANGE;
				else if (is_full) err_d = bvie_pkg::ERR_FULL;
				else len_d = len_q + CW'(1);
			end
			bvie_pkg::OP_ERASE: begin
				if (idx_bad) err_d = bvie_pkg::ERR_RANGE;
				else len_d = len_q - CW'(1);
			end
			bvie_pkg::OP_PUSH: begin
				if (is_full) err_d = bvie_pkg::ERR_FULL;
				else len_d = len_q + CW'(1);
			end
			bvie_pkg::OP_POP: begin
				if (len_q == '0) err_d = bvie_pkg::ERR_EMPTY;
				else len_d = len_q - CW'(1);
			end
			bvie_pkg::OP_CLEAR: begin
				len_d = '0;
			end
			bvie_pkg::OP_ASSIGN: begin
				if (cnt_bad) err_d = bvie_pkg::ERR_FULL;
				else len_d = CW'(count);
			end
		endcase
	end

	always_comb begin
		ctrl.commit = accept && (err_d == bvie_pkg::ERR_OK);
		ctrl.op     = op;
		ctrl.idx    = CW'(index);
		ctrl.len    = len_q;
		ctrl.cnt    = CW'(count);
		ctrl.keep   = keep_existing;
		ctrl.val    = value;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic signed [DW-1:0] lower_w;
		logic signed [DW-1:0] upper_w;

		if (i == 0) begin : g_first
			assign lower_w = cell_q[i];
		end else begin : g_lower
			assign lower_w = cell_q[i-1];
		end
		if (i == N - 1) begin : g_last
			assign upper_w = cell_q[i];
		end else begin : g_upper
			assign upper_w = cell_q[i+1];
		end

		bvie_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.pos   (CW'(i)),
			.lower (lower_w),
			.upper (upper_w),
			.q     (cell_q[i]),
			.d     (cell_d[i])
		);
	end

	// read from current contents, front/back from the contents after the update
	assign back_pos = len_d - CW'(1);

	always_comb begin
		rd_d   = '0;
		back_d = '0;
		for (int i = 0; i < N; i++) begin
			if (op == bvie_pkg::OP_READ && !idx_bad && CW'(i) == CW'(index)) begin
				rd_d = cell_q[i];
			end
			if (len_d != '0 && CW'(i) == back_pos) begin
				back_d = cell_d[i];
			end
		end
		front_d = (len_d == '0) ? '0 : cell_d[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				len_q       <= len_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_q  <= rd_d;
			front_q <= front_d;
			back_q  <= back_d;
			err_q   <= err_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_q;
	assign length      = bvie_pkg::LENGTH_W'(len_q);
	assign front_value = front_q;
	assign back_value  = back_q;
	assign error       = err_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) <= 32'(N))
		else $error("length exceeds capacity");

	a_fail_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept && err_d != bvie_pkg::ERR_OK |=> len_q == $past(len_q))
		else $error("failed request changed the length");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == bvie_pkg::OP_POP && len_q == '0
		|=> err_q == bvie_pkg::ERR_EMPTY && len_q == '0)
		else $error("pop on empty list not flagged");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == bvie_pkg::OP_CLEAR
		|=> len_q == '0 && front_q == '0 && back_q == '0 && err_q == bvie_pkg::ERR_OK)
		else $error("clear left entries");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && len_q == '0 |-> front_q == '0 && back_q == '0)
		else $error("empty list shows front or back value");

endmodule
